### rtl/core/olpd_pkg.sv
// ----------------------------------------------------------------------------
// olpd_pkg
// Shared constants, codes and types of the ordered list push/delete unit.
// ----------------------------------------------------------------------------
package olpd_pkg;

   localparam int LIST_DEPTH  = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int COUNT_WIDTH = $clog2(LIST_DEPTH + 1);

   localparam logic OP_PUSH   = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_EMPTY     = 2'd3;

   typedef logic [VALUE_WIDTH-1:0] value_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic      push_en;
      logic      shift_en;
      value_type key;
   } cell_ctl_type;

endpackage

### rtl/core/olpd_if.sv
// ----------------------------------------------------------------------------
// olpd_if
// Request and response channels: valid/ready handshake with payload.
// ----------------------------------------------------------------------------
interface olpd_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 opcode;
   logic signed [olpd_pkg::VALUE_WIDTH-1:0] item_value;

   modport source (output valid, output opcode, output item_value, input ready);
   modport sink   (input valid, input opcode, input item_value, output ready);
endinterface

interface olpd_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        status;
   logic [olpd_pkg::COUNT_WIDTH-1:0]  entry_count;

   modport source (output valid, output status, output entry_count, input ready);
   modport sink   (input valid, input status, input entry_count, output ready);
endinterface

### rtl/core/olpd_cell.sv
// ----------------------------------------------------------------------------
// olpd_cell
// One list slot: holds a value, flags a match, loads the pushed key when it
// is the tail, takes its right neighbor's value when a delete closes the gap.
// ----------------------------------------------------------------------------
module olpd_cell (
   input  logic                  clock,
   input  olpd_pkg::cell_ctl_type ctl,
   input  logic                  occupied,
   input  logic                  tail,
   input  logic                  seen_in,
   input  olpd_pkg::value_type   next_value,
   output logic                  seen_out,
   output olpd_pkg::value_type   value_out
);
   import olpd_pkg::*;

   value_type value_ff, value_in;
   logic      hit;

   assign hit       = occupied && (value_ff == ctl.key);
   assign seen_out  = seen_in || hit;
   assign value_out = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctl.push_en && tail) begin
         value_in = ctl.key;
      end else if (ctl.shift_en && seen_out) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

### rtl/core/ordered_list_push_delete_unit.sv
// ----------------------------------------------------------------------------
// ordered_list_push_delete_unit
// Bounded ordered list kept in a chain of cells: push at tail, delete first
// match with the later entries closing up.
//
//   channel  dir  handshake        word
//   req_bus  in   valid/ready      opcode, item_value
//   rsp_bus  out  valid/ready      status, entry_count
//
// One word per cycle when not stalled: all cells compare at once, the match
// ripples down the chain and the gap closes in the same edge. A response is
// valid in the cycle after its request. The response register frees itself
// when taken, so a new request is accepted in the cycle the previous response
// leaves. Synchronous reset empties the list; no clearing pass.
// ----------------------------------------------------------------------------
module ordered_list_push_delete_unit (
   input  logic        clock,
   input  logic        reset,
   olpd_req_if.sink    req_bus,
   olpd_rsp_if.source  rsp_bus
);
   import olpd_pkg::*;

   count_type    fill_ff, fill_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [1:0]   status_ff, status_in;
   count_type    count_ff, count_in;
   logic         fire, full, empty, found;
   cell_ctl_type ctl;

   logic        [LIST_DEPTH:0]   seen;
   value_type   [LIST_DEPTH-1:0] cell_value;
   logic        [LIST_DEPTH-1:0] occupied;
   logic        [LIST_DEPTH-1:0] tail;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign fire  = req_bus.valid && req_bus.ready;
   assign full  = (fill_ff == count_type'(LIST_DEPTH));
   assign empty = (fill_ff == '0);
   assign found = seen[LIST_DEPTH];

   assign ctl.key      = value_type'(req_bus.item_value);
   assign ctl.push_en  = fire && (req_bus.opcode == OP_PUSH) && !full;
   assign ctl.shift_en = fire && (req_bus.opcode == OP_DELETE) && found;

   assign seen[0] = 1'b0;

   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      value_type nxt;
      if (i == LIST_DEPTH - 1) begin : g_last
         assign nxt = cell_value[i];
      end else begin : g_mid
         assign nxt = cell_value[i+1];
      end
      assign occupied[i] = count_type'(i) < fill_ff;
      assign tail[i]     = count_type'(i) == fill_ff;

      olpd_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .occupied   (occupied[i]),
         .tail       (tail[i]),
         .seen_in    (seen[i]),
         .next_value (nxt),
         .seen_out   (seen[i+1]),
         .value_out  (cell_value[i])
      );
   end

   always_comb begin
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      status_in    = status_ff;
      count_in     = count_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         case (req_bus.opcode)
            OP_PUSH: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  status_in = ST_OK;
                  fill_in   = fill_ff + count_type'(1);
               end
            end
            OP_DELETE: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else if (!found) begin
                  status_in = ST_NOT_FOUND;
               end else begin
                  status_in = ST_OK;
                  fill_in   = fill_ff - count_type'(1);
               end
            end
            default: begin
               status_in = ST_OK;
            end
         endcase
         count_in = fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
      count_ff  <= count_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = status_ff;
   assign rsp_bus.entry_count = count_ff;

endmodule

### rtl/core/olpd_checker.sv
// ----------------------------------------------------------------------------
// olpd_checker
// Port-level checks of the ordered list push/delete unit, bound to the top.
// ----------------------------------------------------------------------------
module olpd_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [1:0]                rsp_status,
   input logic [olpd_pkg::COUNT_WIDTH-1:0] rsp_entry_count
);
   import olpd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                  && $stable(rsp_entry_count))
      else $error("stalled response changed");

   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request gave no response");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL)
         |-> rsp_entry_count == COUNT_WIDTH'(LIST_DEPTH))
      else $error("full status with list not full");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY) |-> rsp_entry_count == '0)
      else $error("empty status with entries held");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind ordered_list_push_delete_unit olpd_checker u_olpd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_status      (rsp_bus.status),
   .rsp_entry_count (rsp_bus.entry_count)
);

### tb/ordered_list_push_delete_unit_tb.sv
// ----------------------------------------------------------------------------
// ordered_list_push_delete_unit_tb
// Self-checking bench: a queue of list commands feeds a clocked driver, an
// in-bench list predictor computes status and entry count per accepted word,
// and a clocked monitor checks every response word against the oldest
// prediction. Random stall bursts on both channels, one long response hold-off
// and one drain pause.
// ----------------------------------------------------------------------------
module ordered_list_push_delete_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import olpd_pkg::*;

   localparam int RANDOM_CMDS = 800;
   localparam int CALM_TAIL   = 150;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      logic      opcode;
      value_type value;
      bit        drain;
   } list_cmd_type;

   typedef struct packed {
      logic [1:0] status;
      count_type  entry_count;
   } list_outcome_type;

   logic clock;
   logic reset;

   olpd_req_if req_bus ();
   olpd_rsp_if rsp_bus ();

   ordered_list_push_delete_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   list_cmd_type     pending_cmds[$];
   list_outcome_type expected_outcomes[$];
   value_type        held_values[$];

   int  total_cmds = 0;
   int  words_in   = 0;
   int  words_out  = 0;
   int  errors     = 0;
   int  cycles     = 0;
   int  status_hits[4];
   int  peak_count = 0;
   int  hold_left  = 0;
   bit  held_off   = 1'b0;
   bit  idle_on    = 1'b1;
   bit  req_taken  = 1'b0;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic list_outcome_type apply_list_cmd(input logic op, input value_type v);
      list_outcome_type r;
      int pos;
      pos = -1;
      if (op == OP_PUSH) begin
         if (held_values.size() >= LIST_DEPTH) begin
            r.status = ST_FULL;
         end else begin
            held_values.push_back(v);
            r.status = ST_OK;
         end
      end else if (held_values.size() == 0) begin
         r.status = ST_EMPTY;
      end else begin
         foreach (held_values[i])
            if (pos < 0 && held_values[i] == v) pos = i;
         if (pos < 0) begin
            r.status = ST_NOT_FOUND;
         end else begin
            held_values.delete(pos);
            r.status = ST_OK;
         end
      end
      r.entry_count = count_type'(held_values.size());
      status_hits[r.status]++;
      if (held_values.size() > peak_count) peak_count = held_values.size();
      return r;
   endfunction

   task automatic queue_cmd(input logic op, input value_type v, input bit drain);
      list_cmd_type c;
      c.opcode = op;
      c.value  = v;
      c.drain  = drain;
      pending_cmds.push_back(c);
   endtask

   // response check first, then prediction of the word accepted at this edge
   always @(posedge clock) begin
      list_outcome_type want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            words_out++;
            if (expected_outcomes.size() == 0) begin
               $error("unexpected response word: status %0d, entry_count %0d",
                      rsp_bus.status, rsp_bus.entry_count);
               errors++;
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp_bus.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
                  errors++;
               end
               if (rsp_bus.entry_count !== want.entry_count) begin
                  $error("entry_count: expected %0d, got %0d",
                         want.entry_count, rsp_bus.entry_count);
                  errors++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            expected_outcomes.push_back(apply_list_cmd(req_bus.opcode, req_bus.item_value));
            words_in++;
            req_taken <= 1'b1;
            if ($urandom_range(0, 49) == 0) idle_on <= !idle_on;
         end else begin
            req_taken <= 1'b0;
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      list_cmd_type c;
      static int send_gap = 0;
      if (!reset && !(req_bus.valid && !req_taken)) begin
         if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (pending_cmds.size() > 0 &&
                      !(pending_cmds[0].drain && expected_outcomes.size() > 0)) begin
            c = pending_cmds.pop_front();
            req_bus.opcode     <= c.opcode;
            req_bus.item_value <= c.value;
            req_bus.valid      <= 1'b1;
            if (idle_on && words_in + CALM_TAIL < total_cmds && $urandom_range(0, 5) == 0)
               send_gap = $urandom_range(1, 9);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response ready with stall bursts and one long hold-off
   always @(negedge clock) begin
      static int recv_gap = 0;
      if (!held_off && words_in >= 300) begin
         held_off  = 1'b1;
         hold_left = 80;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_bus.ready <= 1'b0;
      end else if (idle_on && words_in + CALM_TAIL < total_cmds &&
                   $urandom_range(0, 7) == 0) begin
         recv_gap = $urandom_range(1, 9) - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words in, %0d out", cycles, words_in,
                  words_out);
         $display("ordered_list_push_delete_unit: mismatch");
         $finish;
      end
   end

   initial begin
      value_type pool[8];
      value_type corner_vals[4];
      value_type v;
      logic      op;
      int        run_left;
      int        push_pct;
      int        pick;

      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.opcode     = OP_PUSH;
      req_bus.item_value = '0;
      rsp_bus.ready      = 1'b0;
      foreach (status_hits[i]) status_hits[i] = 0;

      corner_vals[0] = 32'h8000_0000;
      corner_vals[1] = 32'h7fff_ffff;
      corner_vals[2] = 32'h0000_0000;
      corner_vals[3] = 32'hffff_ffff;

      // empty, single entry without match, then fill to the top
      queue_cmd(OP_DELETE, 32'd0, 1'b0);
      queue_cmd(OP_PUSH,   32'd5, 1'b0);
      queue_cmd(OP_DELETE, 32'd6, 1'b0);
      queue_cmd(OP_DELETE, 32'd5, 1'b0);
      foreach (corner_vals[i]) queue_cmd(OP_PUSH, corner_vals[i], 1'b0);
      queue_cmd(OP_PUSH, 32'h7fff_ffff, 1'b0);
      for (int i = 0; i < 11; i++) queue_cmd(OP_PUSH, value_type'(100 + i), 1'b0);
      queue_cmd(OP_PUSH,   32'd42,          1'b0);
      queue_cmd(OP_DELETE, 32'h7fff_ffff,   1'b0);
      queue_cmd(OP_DELETE, 32'd12345,       1'b0);
      queue_cmd(OP_DELETE, 32'h8000_0000,   1'b0);

      foreach (pool[i]) pool[i] = $urandom;
      run_left = 0;
      push_pct = 50;
      for (int n = 0; n < RANDOM_CMDS; n++) begin
         if (run_left == 0) begin
            run_left = $urandom_range(10, 60);
            case ($urandom_range(0, 2))
               0: push_pct = 80;
               1: push_pct = 50;
               default: push_pct = 25;
            endcase
            pool[$urandom_range(0, 7)] = $urandom;
         end
         run_left--;
         pick = $urandom_range(0, 9);
         if (pick == 0)
            v = $urandom;
         else if (pick == 1)
            v = corner_vals[$urandom_range(0, 3)];
         else
            v = pool[$urandom_range(0, 7)];
         op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_DELETE;
         queue_cmd(op, v, n == 500);
      end
      total_cmds = pending_cmds.size();

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() > 0) @(posedge clock);
      while (req_bus.valid || expected_outcomes.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("%0d words: %0d ok, %0d full, %0d not found, %0d empty; peak count %0d",
               words_in, status_hits[ST_OK], status_hits[ST_FULL],
               status_hits[ST_NOT_FOUND], status_hits[ST_EMPTY], peak_count);
      $display("%0d response words checked, %0d errors", words_out, errors);
      if (errors == 0 && expected_outcomes.size() == 0)
         $display("ordered_list_push_delete_unit: match");
      else
         $display("ordered_list_push_delete_unit: mismatch");
      $finish;
   end

endmodule
